// ----- sv/dfrws_pkg.sv -----
// ----------------------------------------------------------------------------
// dfrws_pkg
// Shared types and constants for the display frame receiver with waveform
// select: header bytes, register addresses, reset values and result beat.
// ----------------------------------------------------------------------------
package dfrws_pkg;

  // frame header bytes
  localparam logic [7:0] HDR_FIRST  = 8'hA5;
  localparam logic [7:0] HDR_SECOND = 8'h5A;

  // register addresses that select a waveform
  localparam logic [15:0] ADDR_NORMAL = 16'h04DA;
  localparam logic [15:0] ADDR_TOP    = 16'h04DB;
  localparam logic [15:0] ADDR_BOTTOM = 16'h04DC;
  localparam logic [15:0] ADDR_BOTH   = 16'h04DD;

  // value byte that makes the selection take effect
  localparam logic [7:0] SELECT_VALUE = 8'h01;

  // reset value of the read opcode register
  localparam logic [7:0] READ_OPCODE_RST = 8'd131;

  // waveform codes
  localparam logic [1:0] WAVE_NORMAL = 2'd0;
  localparam logic [1:0] WAVE_TOP    = 2'd1;
  localparam logic [1:0] WAVE_BOTTOM = 2'd2;
  localparam logic [1:0] WAVE_BOTH   = 2'd3;

  // one result beat; pins bit0 = A, bit1 = B, bit2 = C
  typedef struct packed {
    logic       frame_done;
    logic       waveform_changed;
    logic [1:0] waveform;
    logic [2:0] pins;
  } result_t;

  // pin levels that go with each waveform
  function automatic logic [2:0] wave_pins(input logic [1:0] wave);
    logic [2:0] pins;
    case (wave)
      WAVE_NORMAL: pins = 3'b010;
      WAVE_TOP:    pins = 3'b100;
      WAVE_BOTTOM: pins = 3'b000;
      WAVE_BOTH:   pins = 3'b011;
      default:     pins = 3'b000;
    endcase
    return pins;
  endfunction

endpackage

// ----- sv/dfrws_parser.sv -----
// ----------------------------------------------------------------------------
// dfrws_parser
// Frame parser state: header hunt, length, payload head capture and the
// waveform / pin state. Produces the result of the current byte in the same
// cycle and updates its state when the byte is taken.
// ----------------------------------------------------------------------------
module dfrws_parser import dfrws_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       take_i,
  input  logic [7:0] rx_byte_i,
  input  logic [7:0] read_opcode_i,
  output result_t    result_o
);

  // parser phases
  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_SYNC = 2'd1;
  localparam logic [1:0] PH_LEN  = 2'd2;
  localparam logic [1:0] PH_PAY  = 2'd3;

  logic [1:0] phase_q, phase_d;
  logic [8:0] cnt_q, cnt_d;
  logic [7:0] len_q, len_d;
  logic [1:0] wave_q, wave_d;
  logic [2:0] pins_q, pins_d;
  logic [7:0] head_q [4];

  logic       head_we;
  logic [8:0] pos;
  logic [8:0] cnt_inc;
  logic       last;
  logic [7:0] value_byte;
  logic [15:0] addr;
  logic       hit;
  logic [1:0] hit_wave;
  logic       done;
  logic       changed;

  // payload position and end of frame
  assign pos     = cnt_q - 9'd3;
  assign cnt_inc = cnt_q + 9'd1;
  assign last    = ({1'b0, cnt_inc} >= ({2'b00, len_q} + 10'd3));
  assign head_we = (phase_q == PH_PAY) && (cnt_q >= 9'd3) && (pos < 9'd4);

  // value byte may be arriving right now when the frame ends on it
  assign value_byte = (head_we && (pos[1:0] == 2'd3)) ? rx_byte_i : head_q[3];
  assign addr       = {head_q[1], head_q[2]};

  // address decode
  always_comb begin
    hit      = 1'b1;
    hit_wave = WAVE_NORMAL;
    case (addr)
      ADDR_NORMAL: hit_wave = WAVE_NORMAL;
      ADDR_TOP:    hit_wave = WAVE_TOP;
      ADDR_BOTTOM: hit_wave = WAVE_BOTTOM;
      ADDR_BOTH:   hit_wave = WAVE_BOTH;
      default:     hit      = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    len_d   = len_q;
    wave_d  = wave_q;
    pins_d  = pins_q;
    done    = 1'b0;
    changed = 1'b0;
    case (phase_q)
      PH_HUNT: begin
        if (rx_byte_i == HDR_FIRST) begin
          cnt_d   = 9'd1;
          phase_d = PH_SYNC;
        end
      end
      PH_SYNC: begin
        if (rx_byte_i == HDR_SECOND) begin
          cnt_d   = 9'd2;
          phase_d = PH_LEN;
        end else begin
          cnt_d   = 9'd0;
          phase_d = PH_HUNT;
        end
      end
      PH_LEN: begin
        len_d   = rx_byte_i;
        cnt_d   = 9'd3;
        phase_d = PH_PAY;
      end
      default: begin
        cnt_d = cnt_inc;
        if (last) begin
          done    = 1'b1;
          changed = (len_q >= 8'd4) && (head_q[0] == read_opcode_i) &&
                    (value_byte == SELECT_VALUE) && hit;
          cnt_d   = 9'd0;
          len_d   = 8'd0;
          phase_d = PH_HUNT;
          if (changed) begin
            wave_d = hit_wave;
            pins_d = wave_pins(hit_wave);
          end
        end
      end
    endcase
  end

  // control and waveform state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      cnt_q   <= 9'd0;
      len_q   <= 8'd0;
      wave_q  <= WAVE_NORMAL;
      pins_q  <= 3'b000;
    end else if (take_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      len_q   <= len_d;
      wave_q  <= wave_d;
      pins_q  <= pins_d;
    end
  end

  // payload head capture
  always_ff @(posedge clk_i) begin
    if (take_i && head_we) begin
      head_q[pos[1:0]] <= rx_byte_i;
    end
  end

  assign result_o.frame_done       = done;
  assign result_o.waveform_changed = changed;
  assign result_o.waveform         = wave_d;
  assign result_o.pins             = pins_d;

endmodule

// ----- sv/display_frame_receiver_waveform_select_top.sv -----
// One received byte is taken per clock while the input is not stalled, and each
// byte yields exactly one result beat, registered and shown the cycle after the
// byte is taken when the output register is free. The parser decides a byte in
// combinational logic; an output register backed by a one-beat skid register
// lets the input keep taking bytes while a result waits, so the sustained rate
// is one byte per cycle as long as results are drained. The input stalls only
// when both the output and skid registers hold beats.
// ----------------------------------------------------------------------------
// display_frame_receiver_waveform_select_top
// Serial frame parser that picks a display waveform and drives three pins
// from register read replies carried in 0xA5 0x5A framed packets.
// ----------------------------------------------------------------------------
module display_frame_receiver_waveform_select_top import dfrws_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  // input beats
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] rx_byte_i,
  // result beats
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic       frame_done_o,
  output logic       waveform_changed_o,
  output logic [1:0] waveform_o,
  output logic       pin_a_o,
  output logic       pin_b_o,
  output logic       pin_c_o
);

  logic [7:0] read_opcode_q;
  logic       take;
  logic       out_free;
  result_t    new_res;
  logic       out_valid_q, out_valid_d;
  result_t    out_q, out_d;
  logic       skid_valid_q, skid_valid_d;
  result_t    skid_q, skid_d;

  // read opcode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      read_opcode_q <= READ_OPCODE_RST;
    end else if (cfg_we_i) begin
      read_opcode_q <= cfg_wdata_i;
    end
  end

  assign in_stall_o = skid_valid_q;
  assign take       = in_valid_i && !skid_valid_q;
  assign out_free   = !out_valid_q || !out_stall_i;

  dfrws_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .take_i       (take),
    .rx_byte_i    (rx_byte_i),
    .read_opcode_i(read_opcode_q),
    .result_o     (new_res)
  );

  // output register and skid steering
  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (out_free) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = take;
        out_d       = new_res;
      end
    end else if (take) begin
      skid_valid_d = 1'b1;
      skid_d       = new_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign out_valid_o        = out_valid_q;
  assign frame_done_o       = out_q.frame_done;
  assign waveform_changed_o = out_q.waveform_changed;
  assign waveform_o         = out_q.waveform;
  assign pin_a_o            = out_q.pins[0];
  assign pin_b_o            = out_q.pins[1];
  assign pin_c_o            = out_q.pins[2];

  // skid holds a beat only behind a full output register
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register full while output register empty");

  // a waveform change is only reported on a completed frame
  a_change_needs_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && waveform_changed_o) |-> frame_done_o)
    else $error("waveform change without frame completion");

  // pins follow the selected waveform
  a_pins_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && waveform_changed_o) |->
      ({pin_c_o, pin_b_o, pin_a_o} == wave_pins(waveform_o)))
    else $error("pin levels do not match selected waveform");

  // skid only fills while the output side is stalled
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_valid_q) |-> $past(out_stall_i))
    else $error("skid filled without output stall");

endmodule

// ----- bench/tb_display_frame_receiver_waveform_select_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_display_frame_receiver_waveform_select_top
// Self-checking bench for the serial frame parser. A short table of bytes
// covers the header hunt, zero and short lengths and one waveform select.
// Random well-formed frames, noise and broken headers follow under several
// read opcode settings. Every result beat is checked against a local model
// of the parser or a typed table row, with random idle cycles on both sides.
// ----------------------------------------------------------------------------
module tb_display_frame_receiver_waveform_select_top;
  import dfrws_pkg::*;

  // parser phases of the local model
  typedef enum logic [1:0] {
    SEEK_FIRST,
    SEEK_SECOND,
    GET_LENGTH,
    GET_PAYLOAD
  } hunt_e;

  // one row of the directed table
  typedef struct packed {
    logic [7:0] rx;
    logic       typed;
    result_t    want;
  } probe_t;

  localparam result_t QUIET         = '{1'b0, 1'b0, WAVE_NORMAL, 3'b000};
  localparam result_t ZERO_LEN_DONE = '{1'b1, 1'b0, WAVE_NORMAL, 3'b000};
  localparam result_t BOTH_SELECTED = '{1'b1, 1'b1, WAVE_BOTH, 3'b011};
  localparam result_t SHORT_DONE    = '{1'b1, 1'b0, WAVE_BOTH, 3'b011};

  localparam int PHASE_BYTES = 290;

  // header hunt, zero length, one select, then a short frame
  localparam probe_t DIRECTED [21] = '{
    '{8'h00, 1'b1, QUIET},
    '{8'hFF, 1'b1, QUIET},
    '{8'hA5, 1'b1, QUIET},
    '{8'hA5, 1'b1, QUIET},
    '{8'h5A, 1'b1, QUIET},
    '{8'hA5, 1'b1, QUIET},
    '{8'h5A, 1'b1, QUIET},
    '{8'h00, 1'b1, QUIET},
    '{8'hFF, 1'b1, ZERO_LEN_DONE},
    '{8'hA5, 1'b0, QUIET},
    '{8'h5A, 1'b0, QUIET},
    '{8'h04, 1'b0, QUIET},
    '{8'h83, 1'b0, QUIET},
    '{8'h04, 1'b0, QUIET},
    '{8'hDD, 1'b0, QUIET},
    '{8'h01, 1'b1, BOTH_SELECTED},
    '{8'hA5, 1'b0, QUIET},
    '{8'h5A, 1'b0, QUIET},
    '{8'h02, 1'b0, QUIET},
    '{8'h83, 1'b0, QUIET},
    '{8'h04, 1'b1, SHORT_DONE}
  };

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       cfg_we_i    = 1'b0;
  logic [7:0] cfg_wdata_i = 8'h00;
  logic       in_valid_i  = 1'b0;
  logic [7:0] rx_byte_i   = 8'h00;
  logic       out_stall_i = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic       frame_done_o;
  logic       waveform_changed_o;
  logic [1:0] waveform_o;
  logic       pin_a_o;
  logic       pin_b_o;
  logic       pin_c_o;

  // model state
  logic [7:0] opcode_m = READ_OPCODE_RST;
  hunt_e      phase_m  = SEEK_FIRST;
  logic [8:0] count_m  = 9'd0;
  logic [7:0] len_m    = 8'd0;
  logic [7:0] head_m [4];
  logic [1:0] wave_m   = WAVE_NORMAL;
  logic [2:0] pins_m   = 3'b000;

  result_t beat_q [$];
  int      bytes_sent = 0;
  int      errors     = 0;
  int      take_wait  = 0;
  bit      send_calm  = 1'b0;
  bit      take_calm  = 1'b0;

  display_frame_receiver_waveform_select_top dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .rx_byte_i          (rx_byte_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .frame_done_o       (frame_done_o),
    .waveform_changed_o (waveform_changed_o),
    .waveform_o         (waveform_o),
    .pin_a_o            (pin_a_o),
    .pin_b_o            (pin_b_o),
    .pin_c_o            (pin_c_o)
  );

  always #5 clk_i = ~clk_i;

  // idle cycles per beat, with calm stretches of back-to-back beats
  function automatic int draw_wait(inout bit calm);
    if ($urandom_range(0, 39) == 0) calm = ~calm;
    return calm ? 0 : $urandom_range(0, 19);
  endfunction

  // advance the frame parser model by one byte and return its result beat
  function automatic result_t parse_byte(input logic [7:0] b);
    result_t    r;
    logic [8:0] pos;
    logic [15:0] addr;
    logic [1:0] w;
    logic [2:0] p;
    bit         hit;
    r   = QUIET;
    hit = 1'b0;
    w   = WAVE_NORMAL;
    p   = 3'b000;
    case (phase_m)
      SEEK_FIRST: begin
        if (b == HDR_FIRST) begin
          count_m = 9'd1;
          phase_m = SEEK_SECOND;
        end
      end
      SEEK_SECOND: begin
        // a wrong second byte is dropped, not retried as a first byte
        if (b == HDR_SECOND) begin
          count_m = 9'd2;
          phase_m = GET_LENGTH;
        end else begin
          count_m = 9'd0;
          phase_m = SEEK_FIRST;
        end
      end
      GET_LENGTH: begin
        len_m   = b;
        count_m = 9'd3;
        phase_m = GET_PAYLOAD;
      end
      default: begin
        pos = count_m - 9'd3;
        if (pos < 9'd4) head_m[pos[1:0]] = b;
        count_m = count_m + 9'd1;
        // at least one payload byte, even for length zero
        if ({1'b0, count_m} >= {2'b00, len_m} + 10'd3) begin
          r.frame_done = 1'b1;
          if (len_m >= 8'd4 && head_m[0] == opcode_m && head_m[3] == SELECT_VALUE) begin
            addr = {head_m[1], head_m[2]};
            hit  = 1'b1;
            case (addr)
              ADDR_NORMAL: begin w = WAVE_NORMAL; p = 3'b010; end
              ADDR_TOP:    begin w = WAVE_TOP;    p = 3'b100; end
              ADDR_BOTTOM: begin w = WAVE_BOTTOM; p = 3'b000; end
              ADDR_BOTH:   begin w = WAVE_BOTH;   p = 3'b011; end
              default:     hit = 1'b0;
            endcase
          end
          if (hit) begin
            wave_m = w;
            pins_m = p;
          end
          r.waveform_changed = hit;
          count_m = 9'd0;
          len_m   = 8'd0;
          phase_m = SEEK_FIRST;
        end
      end
    endcase
    r.waveform = wave_m;
    r.pins     = pins_m;
    return r;
  endfunction

  // send one byte; entered and left at a falling edge
  task automatic put_byte(input logic [7:0] b, input logic typed, input result_t want);
    result_t r;
    int      gap;
    r = parse_byte(b);
    beat_q.push_back(typed ? want : r);
    gap = draw_wait(send_calm);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    bytes_sent++;
    @(negedge clk_i);
  endtask

  // a frame with random length and mostly selecting head bytes
  task automatic put_frame(input bit longest);
    int          len;
    int          n;
    logic [7:0]  op;
    logic [7:0]  val;
    logic [15:0] addr;
    case ($urandom_range(0, 19))
      0, 1, 2: len = $urandom_range(0, 3);
      3, 4:    len = $urandom_range(9, 24);
      default: len = $urandom_range(4, 8);
    endcase
    if (longest) len = 255;
    op  = ($urandom_range(0, 4) != 0) ? opcode_m : 8'($urandom_range(0, 255));
    val = ($urandom_range(0, 4) != 0) ? SELECT_VALUE : 8'($urandom_range(0, 255));
    case ($urandom_range(0, 9))
      0:       addr = 16'($urandom_range(0, 65535));
      1:       addr = $urandom_range(0, 1) ? ADDR_NORMAL - 16'd1 : ADDR_BOTH + 16'd1;
      default: addr = ADDR_NORMAL + 16'($urandom_range(0, 3));
    endcase
    put_byte(HDR_FIRST, 1'b0, QUIET);
    put_byte(HDR_SECOND, 1'b0, QUIET);
    put_byte(8'(len), 1'b0, QUIET);
    n = (len == 0) ? 1 : len;
    for (int i = 0; i < n; i++) begin
      case (i)
        0:       put_byte(op, 1'b0, QUIET);
        1:       put_byte(addr[15:8], 1'b0, QUIET);
        2:       put_byte(addr[7:0], 1'b0, QUIET);
        3:       put_byte(val, 1'b0, QUIET);
        default: put_byte(8'($urandom_range(0, 255)), 1'b0, QUIET);
      endcase
    end
  endtask

  // broken headers and line noise
  task automatic put_junk();
    logic [7:0] b;
    case ($urandom_range(0, 2))
      0: begin
        put_byte(HDR_FIRST, 1'b0, QUIET);
        do b = 8'($urandom_range(0, 255)); while (b == HDR_SECOND);
        put_byte(b, 1'b0, QUIET);
      end
      1: begin
        put_byte(HDR_FIRST, 1'b0, QUIET);
        put_byte(HDR_FIRST, 1'b0, QUIET);
        put_byte(HDR_SECOND, 1'b0, QUIET);
      end
      default: begin
        repeat ($urandom_range(1, 4)) put_byte(8'($urandom_range(0, 255)), 1'b0, QUIET);
      end
    endcase
  endtask

  // let the block go idle, then write the read opcode
  task automatic write_opcode(input logic [7:0] v);
    in_valid_i <= 1'b0;
    while (beat_q.size() != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    opcode_m     = v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic report_field(input string what, input logic [2:0] want, input logic [2:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t ns: %s expected %0d actual %0d", $time, what, want, got);
    end
  endtask

  // result side stall, redrawn after every beat
  always @(negedge clk_i) begin
    if (take_wait > 0) begin
      out_stall_i <= 1'b1;
      take_wait    = take_wait - 1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // check every result beat against the oldest expectation
  always @(posedge clk_i) begin : take_beat
    result_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (beat_q.size() == 0) begin
        errors++;
        $display("%0t ns: result beat with none expected, actual done %0b wave %0d",
                 $time, frame_done_o, waveform_o);
      end else begin
        want = beat_q.pop_front();
        report_field("frame_done", 3'(want.frame_done), 3'(frame_done_o));
        report_field("waveform_changed", 3'(want.waveform_changed), 3'(waveform_changed_o));
        report_field("waveform", 3'(want.waveform), 3'(waveform_o));
        report_field("pin_a", 3'(want.pins[0]), 3'(pin_a_o));
        report_field("pin_b", 3'(want.pins[1]), 3'(pin_b_o));
        report_field("pin_c", 3'(want.pins[2]), 3'(pin_c_o));
      end
      take_wait = draw_wait(take_calm);
    end
  end

  // stimulus
  initial begin
    int         target;
    logic [7:0] setting;
    foreach (head_m[i]) head_m[i] = 8'h00;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (DIRECTED[i]) put_byte(DIRECTED[i].rx, DIRECTED[i].typed, DIRECTED[i].want);

    // reset opcode, both extremes, a random one, then back to reset value
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        1:       setting = 8'h00;
        2:       setting = 8'hFF;
        3:       setting = 8'($urandom_range(1, 254));
        default: setting = READ_OPCODE_RST;
      endcase
      if (ph > 0) write_opcode(setting);
      target = bytes_sent + PHASE_BYTES;
      if (ph == 2) put_frame(1'b1);
      while (bytes_sent < target) begin
        if ($urandom_range(0, 19) < 15) put_frame(1'b0);
        else put_junk();
      end
    end

    in_valid_i <= 1'b0;
    while (beat_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (errors == 0) begin
      $display("display_frame_receiver_waveform_select_top regression: pass");
    end else begin
      $display("display_frame_receiver_waveform_select_top regression: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("display_frame_receiver_waveform_select_top regression: fail");
    $finish;
  end

endmodule

// ----- sim.f -----
sv/dfrws_pkg.sv
sv/dfrws_parser.sv
sv/display_frame_receiver_waveform_select_top.sv
bench/tb_display_frame_receiver_waveform_select_top.sv
